[sv/jsu_pkg.sv]
// Shared types and constants for the JSON string unescaper.
`default_nettype none
package jsu_pkg;

  // Input beat: one string body byte or the end of string marker.
  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } jsu_in_t;

  // Output beat: one decoded byte or the final status item.
  typedef struct packed {
    logic        item_kind;
    logic [7:0]  out_byte;
    logic        status;
    logic [15:0] out_length;
    logic        last_of_run;
  } jsu_out_t;

  // One queued group: up to four decoded bytes, or one status item.
  typedef struct packed {
    logic            is_status;
    logic            status;
    logic [15:0]     length;
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
  } jsu_grp_t;

  // UTF-8 encoding of one code point.
  typedef struct packed {
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
  } jsu_utf8_t;

  typedef enum logic [2:0] {
    MODE_USUAL     = 3'd0,
    MODE_ESC       = 3'd1,
    MODE_HEX       = 3'd2,
    MODE_SUR_SLASH = 3'd3,
    MODE_SUR_U     = 3'd4
  } parse_mode_t;

  localparam int QUEUE_DEPTH = 4;

  localparam logic       REQ_DATA   = 1'b0;
  localparam logic       REQ_END    = 1'b1;
  localparam logic       KIND_BYTE  = 1'b0;
  localparam logic       KIND_STAT  = 1'b1;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_R       = 8'h72;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CTL_BS     = 8'h08;
  localparam logic [7:0] CTL_FF     = 8'h0C;
  localparam logic [7:0] CTL_LF     = 8'h0A;
  localparam logic [7:0] CTL_CR     = 8'h0D;
  localparam logic [7:0] CTL_TAB    = 8'h09;

  localparam logic [5:0] SUR_HI_TAG = 6'b110110;
  localparam logic [5:0] SUR_LO_TAG = 6'b110111;
  localparam logic [20:0] CP_PLANE1 = 21'h10000;
  localparam logic [20:0] CP_MAX1   = 21'h7F;
  localparam logic [20:0] CP_MAX2   = 21'h7FF;
  localparam logic [20:0] CP_MAX3   = 21'hFFFF;

endpackage
`default_nettype wire

[sv/jsu_front.sv]
// Front end: accepts input beats, runs the escape parser and queues output groups.
`default_nettype none
module jsu_front import jsu_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire jsu_in_t  in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output jsu_grp_t      q_grp
);

  localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

  parse_mode_t            mode_r, mode_nxt;
  logic [15:0]            acc_r, acc_nxt;
  logic [2:0]             digits_r, digits_nxt;
  logic                   pend_r, pend_nxt;
  logic [9:0]             pend_bits_r, pend_bits_nxt;
  logic                   err_r, err_nxt;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;

  logic                   accept;
  logic                   is_end;
  logic [7:0]             c;
  logic                   hex_ok;
  logic [3:0]             hex_val;
  logic [7:0]             lc;
  logic [15:0]            acc_shift;
  logic                   hex_done;
  logic                   is_hi;
  logic                   is_lo;
  logic [20:0]            enc_cp;
  jsu_utf8_t              enc;
  logic                   emit;
  jsu_utf8_t              emit_grp;
  logic [LENGTH_BITS:0]   cnt_sum;

  function automatic jsu_utf8_t utf8_encode(input logic [20:0] cp);
    jsu_utf8_t r;
    r = '0;
    if (cp <= CP_MAX1) begin
      r.bytes[0] = cp[7:0];
      r.last_idx = 2'd0;
    end else if (cp <= CP_MAX2) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.last_idx = 2'd1;
    end else if (cp <= CP_MAX3) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.last_idx = 2'd2;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.last_idx = 2'd3;
    end
    return r;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_end   = (in_data.req_type == REQ_END);
  assign c        = in_data.in_byte;

  assign lc = c | 8'h20;
  always_comb begin
    hex_ok  = 1'b0;
    hex_val = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_ok  = 1'b1;
      hex_val = c[3:0];
    end else if (lc >= 8'h61 && lc <= 8'h66) begin
      hex_ok  = 1'b1;
      hex_val = 4'(lc - 8'h57);
    end
  end

  assign acc_shift = {acc_r[11:0], hex_val};
  assign hex_done  = (digits_r <= 3'd1);
  assign is_hi     = (acc_shift[15:10] == SUR_HI_TAG);
  assign is_lo     = (acc_shift[15:10] == SUR_LO_TAG);
  // A completed pair lands in the supplementary planes.
  assign enc_cp    = pend_r ? (CP_PLANE1 + {1'b0, pend_bits_r, acc_shift[9:0]})
                            : {5'd0, acc_shift};
  assign enc       = utf8_encode(enc_cp);

  // Next parse mode.
  always_comb begin
    mode_nxt = mode_r;
    if (accept) begin
      if (is_end) begin
        mode_nxt = MODE_USUAL;
      end else if (!err_r) begin
        unique case (mode_r)
          MODE_USUAL: begin
            if (c == CH_BSLASH) mode_nxt = MODE_ESC;
          end
          MODE_ESC: begin
            case (c) inside
              CH_U: mode_nxt = MODE_HEX;
              CH_QUOTE, CH_SLASH, CH_BSLASH, CH_B, CH_F, CH_N, CH_R, CH_T:
                mode_nxt = MODE_USUAL;
              default: mode_nxt = MODE_ESC;
            endcase
          end
          MODE_HEX: begin
            if (hex_ok && hex_done) begin
              if (pend_r) begin
                if (is_lo) mode_nxt = MODE_USUAL;
              end else if (is_hi) begin
                mode_nxt = MODE_SUR_SLASH;
              end else if (!is_lo) begin
                mode_nxt = MODE_USUAL;
              end
            end
          end
          MODE_SUR_SLASH: begin
            if (c == CH_BSLASH) mode_nxt = MODE_SUR_U;
          end
          MODE_SUR_U: begin
            if (c == CH_U) mode_nxt = MODE_HEX;
          end
          default: mode_nxt = MODE_USUAL;
        endcase
      end
    end
  end

  // Data path registers, error flag and decoded group.
  always_comb begin
    acc_nxt       = acc_r;
    digits_nxt    = digits_r;
    pend_nxt      = pend_r;
    pend_bits_nxt = pend_bits_r;
    err_nxt       = err_r;
    emit          = 1'b0;
    emit_grp      = '0;
    if (accept && !is_end && !err_r) begin
      unique case (mode_r)
        MODE_USUAL: begin
          if (c == CH_QUOTE || c < CH_SPACE) begin
            err_nxt = 1'b1;
          end else if (c != CH_BSLASH) begin
            emit              = 1'b1;
            emit_grp.bytes[0] = c;
          end
        end
        MODE_ESC: begin
          emit = 1'b1;
          case (c) inside
            CH_U: begin
              emit       = 1'b0;
              acc_nxt    = '0;
              digits_nxt = 3'd4;
            end
            CH_QUOTE, CH_SLASH, CH_BSLASH: emit_grp.bytes[0] = c;
            CH_B: emit_grp.bytes[0] = CTL_BS;
            CH_F: emit_grp.bytes[0] = CTL_FF;
            CH_N: emit_grp.bytes[0] = CTL_LF;
            CH_R: emit_grp.bytes[0] = CTL_CR;
            CH_T: emit_grp.bytes[0] = CTL_TAB;
            default: begin
              emit    = 1'b0;
              err_nxt = 1'b1;
            end
          endcase
        end
        MODE_HEX: begin
          if (!hex_ok) begin
            err_nxt = 1'b1;
          end else begin
            acc_nxt = acc_shift;
            if (digits_r != 3'd0) digits_nxt = digits_r - 3'd1;
            if (hex_done) begin
              if (pend_r) begin
                if (is_lo) begin
                  emit     = 1'b1;
                  emit_grp = enc;
                  pend_nxt = 1'b0;
                end else begin
                  err_nxt = 1'b1;
                end
              end else if (is_hi) begin
                pend_nxt      = 1'b1;
                pend_bits_nxt = acc_shift[9:0];
              end else if (is_lo) begin
                err_nxt = 1'b1;
              end else begin
                emit     = 1'b1;
                emit_grp = enc;
              end
            end
          end
        end
        MODE_SUR_SLASH: begin
          if (c != CH_BSLASH) err_nxt = 1'b1;
        end
        MODE_SUR_U: begin
          if (c == CH_U) begin
            acc_nxt    = '0;
            digits_nxt = 3'd4;
          end else begin
            err_nxt = 1'b1;
          end
        end
        default: err_nxt = 1'b1;
      endcase
    end
  end

  assign cnt_sum = {1'b0, cnt_r} + (LENGTH_BITS+1)'({1'b0, emit_grp.last_idx} + 3'd1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (emit) begin
      cnt_nxt = (cnt_sum > {1'b0, CNT_MAX}) ? CNT_MAX : cnt_sum[LENGTH_BITS-1:0];
    end
  end

  always_comb begin
    q_push = accept && (is_end || emit);
    q_grp  = '0;
    if (is_end) begin
      q_grp.is_status = 1'b1;
      q_grp.status    = err_r || (mode_r != MODE_USUAL);
      q_grp.length    = 16'(cnt_r);
    end else begin
      q_grp.bytes    = emit_grp.bytes;
      q_grp.last_idx = emit_grp.last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && is_end)) begin
      mode_r      <= MODE_USUAL;
      acc_r       <= '0;
      digits_r    <= '0;
      pend_r      <= 1'b0;
      pend_bits_r <= '0;
      err_r       <= 1'b0;
      cnt_r       <= '0;
    end else begin
      mode_r      <= mode_nxt;
      acc_r       <= acc_nxt;
      digits_r    <= digits_nxt;
      pend_r      <= pend_nxt;
      pend_bits_r <= pend_bits_nxt;
      err_r       <= err_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/jsu_queue.sv]
// Small flop queue of decoded groups between the front and back ends.
`default_nettype none
module jsu_queue import jsu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire jsu_grp_t push_grp,
  input  wire logic     pop,
  output jsu_grp_t      head,
  output logic          empty,
  output logic          full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  jsu_grp_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]       cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_grp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/jsu_back.sv]
// Back end: serializes queued groups into output beats through an output register.
`default_nettype none
module jsu_back import jsu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire jsu_grp_t head,
  input  wire logic     empty,
  output logic          pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output jsu_out_t      out_data
);

  logic       out_valid_r;
  jsu_out_t   out_data_r, out_data_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       load;
  logic       take;
  logic       last;

  assign load = !out_valid_r || out_ready;
  assign take = load && !empty;
  assign last = head.is_status || (idx_r == head.last_idx);
  assign pop  = take && last;

  always_comb begin
    idx_nxt = idx_r;
    if (take) idx_nxt = last ? 2'd0 : idx_r + 2'd1;
  end

  always_comb begin
    out_data_nxt = '0;
    if (head.is_status) begin
      out_data_nxt.item_kind  = KIND_STAT;
      out_data_nxt.status     = head.status;
      out_data_nxt.out_length = head.length;
    end else begin
      out_data_nxt.item_kind = KIND_BYTE;
      out_data_nxt.out_byte  = head.bytes[idx_r];
    end
    out_data_nxt.last_of_run = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) out_valid_r <= !empty;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[sv/json_string_unescape.sv]
// Top level of the JSON string unescaper: front end, group queue and back end.
//
// Usage: send the bytes of an unquoted JSON string body on the in_ channel
// (req_type 0), then one end marker (req_type 1). Each data beat yields zero
// to four decoded UTF-8 bytes on the out_ channel; the end marker yields one
// status beat with the error flag and the saturated output length, and
// returns the decoder to its reset state. last_of_run marks the final output
// beat caused by one input beat. After an error, data beats give no output.
// An accepted input beat goes into the group queue, and its first output
// beat is loaded from there into the output register. Throughput: one input
// beat per cycle while each gives at most one output beat and the receiver
// is ready; the back end sends one beat per cycle while the receiver is
// ready, one per decoded byte, and a four-entry group queue absorbs the spread.
// When the receiver stalls, the output register holds its beat, the queue
// fills and in_ready drops once all four entries are taken.
// Reset (rst_n low, synchronous) empties the queue and the output register
// and clears the parser state.
`default_nettype none
module json_string_unescape import jsu_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire jsu_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output jsu_out_t      out_data
);

  logic     q_push;
  jsu_grp_t q_grp;
  logic     q_pop;
  jsu_grp_t q_head;
  logic     q_empty;
  logic     q_full;

  jsu_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_grp    (q_grp)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_grp (q_grp),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[test/jsu_checker.sv]
// Scoreboard for json_string_unescape: predicts the decoded beats and checks the out_ channel.
`timescale 1ns / 1ps
module jsu_checker import jsu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_ready,
  input  wire jsu_in_t  in_data,
  input  wire logic     out_valid,
  input  wire logic     out_ready,
  input  wire jsu_out_t out_data,
  output int            fail_count,
  output int            owed,
  output int            beats_checked,
  output int            error_ends
);

  // Decoder state, kept apart from the block.
  parse_mode_t esc_mode;
  logic [15:0] hex_acc;
  logic [2:0]  digits_to_go;
  logic [15:0] high_half;
  logic        sticky_err;
  logic [15:0] byte_count;

  jsu_out_t decoded_q[$];
  int       mismatches = 0;
  int       checked = 0;
  int       err_seen_ends = 0;

  initial begin
    fail_count = 0;
    owed = 0;
    beats_checked = 0;
    error_ends = 0;
  end

  task automatic clear_decoder();
    esc_mode = MODE_USUAL;
    hex_acc = '0;
    digits_to_go = '0;
    high_half = '0;
    sticky_err = 1'b0;
    byte_count = '0;
  endtask

  function automatic int hex_nibble(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (lc >= "a" && lc <= "f") return int'(lc - "a") + 10;
    return -1;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    jsu_out_t e;
    e = '0;
    e.item_kind = KIND_BYTE;
    e.out_byte = b;
    e.last_of_run = last;
    decoded_q.push_back(e);
    if (byte_count != 16'hFFFF) byte_count++;
  endtask

  task automatic push_code_point(input logic [20:0] cp);
    if (cp <= CP_MAX1) begin
      push_byte(cp[7:0], 1'b1);
    end else if (cp <= CP_MAX2) begin
      push_byte({3'b110, cp[10:6]}, 1'b0);
      push_byte({2'b10, cp[5:0]}, 1'b1);
    end else if (cp <= CP_MAX3) begin
      push_byte({4'b1110, cp[15:12]}, 1'b0);
      push_byte({2'b10, cp[11:6]}, 1'b0);
      push_byte({2'b10, cp[5:0]}, 1'b1);
    end else begin
      push_byte({5'b11110, cp[20:18]}, 1'b0);
      push_byte({2'b10, cp[17:12]}, 1'b0);
      push_byte({2'b10, cp[11:6]}, 1'b0);
      push_byte({2'b10, cp[5:0]}, 1'b1);
    end
  endtask

  task automatic unescape_beat(input jsu_in_t beat);
    logic [7:0]  c;
    int          h;
    jsu_out_t    st;
    c = beat.in_byte;
    if (beat.req_type == REQ_END) begin
      st = '0;
      st.item_kind = KIND_STAT;
      st.status = sticky_err || (esc_mode != MODE_USUAL);
      st.out_length = byte_count;
      st.last_of_run = 1'b1;
      if (st.status) err_seen_ends++;
      decoded_q.push_back(st);
      clear_decoder();
      return;
    end
    // Once an error is latched, data beats are swallowed until the end marker.
    if (sticky_err) return;
    case (esc_mode)
      MODE_USUAL: begin
        if (c == CH_QUOTE || c < CH_SPACE) sticky_err = 1'b1;
        else if (c == CH_BSLASH) esc_mode = MODE_ESC;
        else push_byte(c, 1'b1);
      end
      MODE_ESC: begin
        esc_mode = MODE_USUAL;
        case (c) inside
          CH_U: begin
            hex_acc = '0;
            digits_to_go = 3'd4;
            esc_mode = MODE_HEX;
          end
          CH_QUOTE, CH_SLASH, CH_BSLASH: push_byte(c, 1'b1);
          CH_B: push_byte(CTL_BS, 1'b1);
          CH_F: push_byte(CTL_FF, 1'b1);
          CH_N: push_byte(CTL_LF, 1'b1);
          CH_R: push_byte(CTL_CR, 1'b1);
          CH_T: push_byte(CTL_TAB, 1'b1);
          default: begin
            esc_mode = MODE_ESC;
            sticky_err = 1'b1;
          end
        endcase
      end
      MODE_HEX: begin
        h = hex_nibble(c);
        if (h < 0) begin
          sticky_err = 1'b1;
        end else begin
          hex_acc = {hex_acc[11:0], h[3:0]};
          if (digits_to_go != 0) digits_to_go--;
          if (digits_to_go == 0) begin
            if (high_half != 0) begin
              // Second half of a surrogate pair must be a low surrogate.
              if (hex_acc[15:10] != SUR_LO_TAG) begin
                sticky_err = 1'b1;
              end else begin
                esc_mode = MODE_USUAL;
                push_code_point(CP_PLANE1 + {high_half[9:0], 10'd0} + hex_acc[9:0]);
                high_half = '0;
              end
            end else if (hex_acc[15:10] == SUR_HI_TAG) begin
              high_half = hex_acc;
              esc_mode = MODE_SUR_SLASH;
            end else if (hex_acc[15:10] == SUR_LO_TAG) begin
              sticky_err = 1'b1;
            end else begin
              esc_mode = MODE_USUAL;
              push_code_point({5'd0, hex_acc});
            end
          end
        end
      end
      MODE_SUR_SLASH: begin
        if (c == CH_BSLASH) esc_mode = MODE_SUR_U;
        else sticky_err = 1'b1;
      end
      MODE_SUR_U: begin
        if (c == CH_U) begin
          hex_acc = '0;
          digits_to_go = 3'd4;
          esc_mode = MODE_HEX;
        end else begin
          sticky_err = 1'b1;
        end
      end
      default: sticky_err = 1'b1;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    jsu_out_t want;
    if (!rst_n) begin
      clear_decoder();
      decoded_q.delete();
    end else begin
      if (in_valid && in_ready) unescape_beat(in_data);
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("output beat with nothing owed: kind %0d byte 0x%02h status %0d",
                 out_data.item_kind, out_data.out_byte, out_data.status);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          check_field("item_kind", 16'(want.item_kind), 16'(out_data.item_kind));
          check_field("out_byte", 16'(want.out_byte), 16'(out_data.out_byte));
          check_field("status", 16'(want.status), 16'(out_data.status));
          check_field("out_length", want.out_length, out_data.out_length);
          check_field("last_of_run", 16'(want.last_of_run), 16'(out_data.last_of_run));
          checked++;
        end
      end
    end
    owed <= decoded_q.size();
    fail_count <= mismatches;
    beats_checked <= checked;
    error_ends <= err_seen_ends;
  end

endmodule

[test/tb_top.sv]
// Testbench top for json_string_unescape: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_top import jsu_pkg::*;;

  localparam int TARGET_BEATS = 470;
  localparam int HOLD_AT      = 50;
  localparam int HOLD_CYCLES  = 80;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  jsu_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  jsu_out_t out_data;

  int fail_count;
  int owed;
  int beats_checked;
  int error_ends;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int beats_sent = 0;
  int strings_sent = 0;
  int accepted = 0;
  int cycles = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  logic [7:0] esc_letters [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

  json_string_unescape u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  jsu_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .owed         (owed),
    .beats_checked(beats_checked),
    .error_ends   (error_ends)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (in_valid && in_ready) accepted <= accepted + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d beats still owed", cycles, owed);
      $display("json_string_unescape verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off while the sender keeps going.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && accepted == HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_beat(input logic req, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{req_type: req, in_byte: b};
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_end();
    send_beat(REQ_END, 8'($urandom_range(255)));
    strings_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(REQ_DATA, s[i]);
    send_end();
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return "0" + 8'(n);
    return ($urandom_range(1) ? "A" : "a") + 8'(n) - 8'd10;
  endfunction

  function automatic logic is_hex_char(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    return (c >= "0" && c <= "9") || (lc >= "a" && lc <= "f");
  endfunction

  function automatic logic is_escape_letter(input logic [7:0] c);
    if (c == CH_U) return 1'b1;
    foreach (esc_letters[i]) if (c == esc_letters[i]) return 1'b1;
    return 1'b0;
  endfunction

  task automatic send_u(input logic [15:0] v);
    send_beat(REQ_DATA, CH_BSLASH);
    send_beat(REQ_DATA, CH_U);
    for (int i = 3; i >= 0; i--) send_beat(REQ_DATA, hex_char(v[i*4 +: 4]));
  endtask

  function automatic logic [15:0] plain_code_point();
    case ($urandom_range(3))
      0: return 16'($urandom_range(16'h007F));
      1: return 16'($urandom_range(16'h07FF, 16'h0080));
      2: return 16'($urandom_range(16'hD7FF, 16'h0800));
      default: return 16'($urandom_range(16'hFFFF, 16'hE000));
    endcase
  endfunction

  // Mostly well-formed strings with random content; about one piece in eight is broken.
  task automatic send_random_string();
    int         pieces;
    int         pick;
    int         digits;
    logic       cut;
    logic [7:0] b;
    pieces = $urandom_range(6, 1);
    cut = 1'b0;
    for (int p = 0; p < pieces && !cut; p++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        do b = 8'($urandom_range(8'hFF, 8'h20)); while (b == CH_QUOTE || b == CH_BSLASH);
        send_beat(REQ_DATA, b);
      end else if (pick < 60) begin
        send_beat(REQ_DATA, CH_BSLASH);
        send_beat(REQ_DATA, esc_letters[$urandom_range(7)]);
      end else if (pick < 78) begin
        send_u(plain_code_point());
      end else if (pick < 88) begin
        send_u(16'($urandom_range(16'hDBFF, 16'hD800)));
        send_u(16'($urandom_range(16'hDFFF, 16'hDC00)));
      end else begin
        case ($urandom_range(5))
          0: send_beat(REQ_DATA, 8'($urandom_range(255)));
          1: begin
            do b = 8'($urandom_range(255)); while (is_escape_letter(b));
            send_beat(REQ_DATA, CH_BSLASH);
            send_beat(REQ_DATA, b);
          end
          2: begin
            send_beat(REQ_DATA, CH_BSLASH);
            send_beat(REQ_DATA, CH_U);
            digits = $urandom_range(3);
            for (int i = 0; i < digits; i++) send_beat(REQ_DATA, hex_char(4'($urandom_range(15))));
            do b = 8'($urandom_range(255)); while (is_hex_char(b));
            send_beat(REQ_DATA, b);
          end
          3: send_u(16'($urandom_range(16'hDFFF, 16'hDC00)));
          4: begin
            // High surrogate followed by something other than a low surrogate escape.
            send_u(16'($urandom_range(16'hDBFF, 16'hD800)));
            case ($urandom_range(2))
              0: begin
                do b = 8'($urandom_range(255)); while (b == CH_BSLASH);
                send_beat(REQ_DATA, b);
              end
              1: begin
                do b = 8'($urandom_range(255)); while (b == CH_U);
                send_beat(REQ_DATA, CH_BSLASH);
                send_beat(REQ_DATA, b);
              end
              default: send_u($urandom_range(1) ? 16'($urandom_range(16'hDBFF))
                                                : 16'($urandom_range(16'hFFFF, 16'hE000)));
            endcase
          end
          default: begin
            // End marker arrives in the middle of an escape.
            send_beat(REQ_DATA, CH_BSLASH);
            digits = $urandom_range(4);
            if (digits > 0) send_beat(REQ_DATA, CH_U);
            for (int i = 1; i < digits; i++) send_beat(REQ_DATA, hex_char(4'($urandom_range(15))));
            cut = 1'b1;
          end
        endcase
      end
    end
    send_end();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Byte extremes, null code point, then a bare quote with data after it.
    send_beat(REQ_DATA, 8'hFF);
    send_text(" \\u0000\"A");
    send_beat(REQ_DATA, 8'h00);
    send_end();
    send_text("\\q");
    send_text("\\u0g");
    send_text("\\uDC00");
    send_text("\\");

    while (beats_sent < TARGET_BEATS) begin
      case (beats_sent * 4 / TARGET_BEATS)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      send_random_string();
    end
    in_valid <= 1'b0;

    while (owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d beats in %0d strings: plain bytes, escapes, BMP and paired code points,",
             beats_sent, strings_sent);
    $display("and malformed input; %0d output beats checked, %0d strings ended in error.",
             beats_checked, error_ends);
    if (fail_count == 0 && owed == 0) begin
      $display("json_string_unescape verification clean");
    end else begin
      $display("json_string_unescape verification failed");
    end
    $finish;
  end

endmodule
